[rtl/dmx_pkg.sv]
// Shared constants, types and helpers of the dual motor duty mixer.
package dmx_pkg;

    localparam int THROTTLE_RANGE     = 1000;
    localparam int TEMP_RAMP_SPAN     = 20;
    localparam int UNDERVOLT_MIN_SPAN = 1000;

    localparam int NUM_W = 32;                 // product / dividend width
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [15:0] RANGE_U    = 16'(THROTTLE_RANGE);
    localparam logic [16:0] RANGE2_U   = 17'(2 * THROTTLE_RANGE);
    localparam logic [15:0] UV_MIN_U   = 16'(UNDERVOLT_MIN_SPAN);
    localparam logic [15:0] TSPAN_U    = 16'(TEMP_RAMP_SPAN);

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_PERIOD   = 3'd0,
        CFG_DEADTIME = 3'd1,
        CFG_TLIMIT   = 3'd2,
        CFG_VLIMIT   = 3'd3,
        CFG_STRETCH  = 3'd4,
        CFG_SPLIT    = 3'd5,
        CFG_FLAGS    = 3'd6
    } cfg_index_t;

    // split modes
    localparam logic [1:0] MODE_BOOST_FWD = 2'd1;
    localparam logic [1:0] MODE_BOOST_ALL = 2'd2;

    // request to the shared multiply-divide unit: a * b / den
    typedef struct packed {
        logic        start;
        logic [15:0] a;
        logic [15:0] b;
        logic [16:0] den;
    } map_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } map_rsp_t;

    function automatic logic signed [16:0] clamp_r(input logic signed [16:0] x);
        logic signed [16:0] r;
        r = $signed({1'b0, RANGE_U});
        if (x > r)
            return r;
        else if (x < -r)
            return -r;
        else
            return x;
    endfunction

    // magnitude limited to the throttle range
    function automatic logic [15:0] mag_r(input logic signed [16:0] x);
        logic signed [16:0] c;
        c = clamp_r(x);
        return (c < 0) ? 16'(-c) : 16'(c);
    endfunction

    function automatic logic [15:0] sat16(input logic [16:0] x);
        return x[16] ? 16'hFFFF : x[15:0];
    endfunction

endpackage

[rtl/dmx_if.sv]
// Channel interfaces: control tick in, leg duties out.
interface dmx_in_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] throttle_one;
    logic signed [10:0] throttle_two;
    logic               armed_one;
    logic               armed_two;
    logic signed [8:0]  temperature_c;
    logic [15:0]        battery_voltage;
    logic [15:0]        current_duty_cap;
    logic [1:0]         mode_select;

    modport source (output valid, throttle_one, throttle_two, armed_one, armed_two,
                    temperature_c, battery_voltage, current_duty_cap, mode_select,
                    input ready);
    modport sink (input valid, throttle_one, throttle_two, armed_one, armed_two,
                  temperature_c, battery_voltage, current_duty_cap, mode_select,
                  output ready);
endinterface

interface dmx_out_if;
    logic        valid;
    logic        ready;
    logic        drive_enabled;
    logic [15:0] duty_common;
    logic [15:0] duty_leg_one;
    logic [15:0] duty_leg_two;
    logic        limit_active;
    logic        low_battery;

    modport source (output valid, drive_enabled, duty_common, duty_leg_one, duty_leg_two,
                    limit_active, low_battery, input ready);
    modport sink (input valid, drive_enabled, duty_common, duty_leg_one, duty_leg_two,
                  limit_active, low_battery, output ready);
endinterface

[rtl/dual_motor_three_leg_duty_mixer.sv]
// Top level: arming, mixing, duty limiting and three-leg split sequencer.
//
//  channel   dir  handshake        contents
//  items     in   valid/ready      throttles, arm flags, temperature, vbat, cap, mode
//  results   out  valid/ready      enable, three leg duties, limit and low-battery flags
//  cfg       in   cfg_we           cfg_index, cfg_data (16 bit)
//
// Each map goes through one shared multiply/divide unit.
// A disarmed tick takes no map, an armed tick takes 2 to 8 maps. items.ready is
// high only while the sequencer idles. A finished result sits in the output register;
// the next item may be taken while it waits. Reset clears the arm latch and loads
// register defaults.
module dual_motor_three_leg_duty_mixer (
    input  logic        clk,
    input  logic        rst_n,
    dmx_in_if.sink      items,
    dmx_out_if.source   results,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dmx_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_TEMP = 12'b000000000010,
        S_CUR  = 12'b000000000100,
        S_UV   = 12'b000000001000,
        S_P1   = 12'b000000010000,
        S_P2   = 12'b000000100000,
        S_CHK  = 12'b000001000000,
        S_SC1  = 12'b000010000000,
        S_SC2  = 12'b000100000000,
        S_MA   = 12'b001000000000,
        S_MB   = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } state_t;

    // configuration
    logic [15:0] period_reg;
    logic [9:0]  dead_reg;
    logic [7:0]  tlim_reg;
    logic [15:0] vlim_reg;
    logic [15:0] stretch_reg;
    logic [1:0]  split_reg;
    logic [7:0]  flags_reg;

    // control
    state_t      state_reg, state_next;
    logic        armed_reg, armed_next;
    logic        issued_reg, issued_next;
    logic [1:0]  tries_reg, tries_next;
    logic        ovalid_reg, ovalid_next;

    // payload
    logic signed [16:0] v1_reg, v1_next, v2_reg, v2_next;
    logic signed [8:0]  temp_reg, temp_next;
    logic [15:0] vbat_reg, vbat_next, cap_reg, cap_next;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] dm_reg, dm_next;
    logic        limit_reg, limit_next, lowbat_reg, lowbat_next;
    logic [16:0] p1_reg, p1_next, p2_reg, p2_next, total_reg, total_next;
    logic [16:0] n1_reg, n1_next, q1_reg, q1_next, q2_reg, q2_next;
    logic        o_en_reg, o_en_next, o_lim_reg, o_lim_next, o_low_reg, o_low_next;
    logic [15:0] o_dc_reg, o_dc_next, o_d1_reg, o_d1_next, o_d2_reg, o_d2_next;

    map_req_t req;
    map_rsp_t rsp;

    dmx_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ---------------- combinational helpers ----------------
    logic signed [16:0] t1, t2, a1v, a2v, l_sum, r_dif, sw1, sw2;
    logic               arm_in;
    logic               v1z, v2z, all_zero, same_sign, pos2, neg2, half_map;
    logic [15:0]        mid;
    logic [14:0]        half_p;
    logic signed [11:0] temp_s, tlim_s, tmax_s, tx_s;
    logic               temp_hot, uv_act;
    logic [15:0]        span;
    logic signed [17:0] uv_d;
    logic [16:0]        dead_dm;
    logic               cur_cut;
    logic [16:0]        dc17, d117, d217, pm;
    logic               map_state, map_active;

    assign t1 = 17'(items.throttle_one);
    assign t2 = 17'(items.throttle_two);

    always_comb
    begin
        arm_in = armed_reg;
        a1v    = '0;
        a2v    = '0;
        if (flags_reg[0])
        begin
            // tied: channel one wins
            if (items.armed_one)
            begin
                a1v = t1; a2v = t1; arm_in = 1'b1;
            end
            else if (items.armed_two)
            begin
                a1v = t2; a2v = t2; arm_in = 1'b1;
            end
            else
                arm_in = 1'b0;
        end
        else
        begin
            if (!armed_reg)
                arm_in = items.armed_one && items.armed_two &&
                         ((t1 == 0 && t2 == 0) || flags_reg[6]);
            else
                arm_in = items.armed_one && items.armed_two;
            if (arm_in)
            begin
                a1v = t1; a2v = t2;
            end
        end
    end

    assign l_sum = (flags_reg[1] && !flags_reg[0]) ? clamp_r(a1v + a2v) : a1v;
    assign r_dif = (flags_reg[1] && !flags_reg[0]) ? clamp_r(a1v - a2v) : a2v;
    assign sw1   = flags_reg[2] ? r_dif : l_sum;
    assign sw2   = flags_reg[2] ? l_sum : r_dif;

    assign v1z       = (v1_reg == 0);
    assign v2z       = (v2_reg == 0);
    assign all_zero  = v1z && v2z;
    assign same_sign = (!v1_reg[16] && !v2_reg[16]) || ((v1_reg[16] || v1z) &&
                       (v2_reg[16] || v2z));
    assign pos2      = (!v1_reg[16] && !v2_reg[16]);   // not both zero here
    assign neg2      = (v1_reg[16] || v1z) && (v2_reg[16] || v2z);
    assign half_map  = (mode_reg == MODE_BOOST_FWD) && same_sign;
    assign mid       = 16'((17'(dm_reg) + 17'd1) >> 1);
    assign half_p    = period_reg[15:1];

    assign temp_s   = 12'(temp_reg);
    assign tlim_s   = $signed({4'b0, tlim_reg});
    assign tmax_s   = tlim_s + $signed({1'b0, 11'(TSPAN_U)});
    assign tx_s     = ((temp_s > tmax_s) ? tmax_s : temp_s) - tlim_s;
    assign temp_hot = (tlim_reg != 8'd0) && (temp_s > tlim_s);

    assign uv_act = (vlim_reg != 16'd0) && (vbat_reg < vlim_reg);
    assign span   = (stretch_reg > UV_MIN_U) ? stretch_reg : UV_MIN_U;
    assign uv_d   = $signed({2'b0, vbat_reg}) - $signed({2'b0, vlim_reg}) +
                    $signed({2'b0, span});

    assign dead_dm = 17'(period_reg) - 17'(dead_reg);
    assign cur_cut = flags_reg[5] && (dm_reg > cap_reg);

    assign map_state  = (state_reg == S_TEMP) || (state_reg == S_UV) ||
                        (state_reg == S_P1) || (state_reg == S_P2) ||
                        (state_reg == S_SC1) || (state_reg == S_SC2) ||
                        (state_reg == S_MA) || (state_reg == S_MB);
    assign map_active = map_state &&
                        !(state_reg == S_TEMP && !temp_hot) &&
                        !(state_reg == S_UV && !uv_act) &&
                        !((state_reg == S_MA || state_reg == S_MB) && half_map &&
                          dm_reg == 16'd0);

    // operands of the shared unit
    always_comb
    begin
        req       = '0;
        req.start = map_active && !issued_reg;
        case (state_reg)
            S_TEMP:
            begin
                req.a   = 16'(tx_s);
                req.b   = (half_p == 15'd0) ? 16'd1 : 16'(half_p - 15'd1);
                req.den = 17'(TSPAN_U);
            end
            S_UV:
            begin
                req.a   = uv_d[17] ? 16'd0 : uv_d[15:0];
                req.b   = dm_reg;
                req.den = 17'(span);
            end
            S_P1:
            begin
                req.a = mag_r(v1_reg); req.b = dm_reg; req.den = 17'(RANGE_U);
            end
            S_P2:
            begin
                req.a = mag_r(v2_reg); req.b = dm_reg; req.den = 17'(RANGE_U);
            end
            S_SC1:
            begin
                req.a = p1_reg[15:0]; req.b = dm_reg; req.den = total_reg;
            end
            S_SC2:
            begin
                req.a = p2_reg[15:0]; req.b = dm_reg; req.den = total_reg;
            end
            S_MA, S_MB:
            begin
                if (half_map)
                begin
                    req.a   = (state_reg == S_MA) ? p1_reg[15:0] : p2_reg[15:0];
                    req.b   = mid;
                    req.den = 17'(dm_reg);
                end
                else
                begin
                    req.a   = 16'(((state_reg == S_MA) ? clamp_r(v1_reg) : clamp_r(v2_reg))
                              + $signed({1'b0, RANGE_U}));
                    req.b   = dm_reg;
                    req.den = RANGE2_U;
                end
            end
            default: ;
        endcase
    end

    // final leg composition
    always_comb
    begin
        pm   = (q1_reg < q2_reg) ? q1_reg : q2_reg;
        dc17 = '0;
        d117 = '0;
        d217 = '0;
        if (all_zero)
        begin
            dc17 = '0;
        end
        else if (mode_reg == MODE_BOOST_ALL)
        begin
            if (pos2)
            begin
                d117 = p1_reg; d217 = p2_reg;
            end
            else if (neg2)
            begin
                dc17 = 17'(dm_reg);
                d117 = 17'(dm_reg) - p1_reg;
                d217 = 17'(dm_reg) - p2_reg;
            end
            else if (v1_reg > v2_reg)
            begin
                dc17 = p2_reg; d117 = total_reg;
            end
            else
            begin
                dc17 = p1_reg; d217 = total_reg;
            end
        end
        else if (half_map)
        begin
            if (pos2)
            begin
                dc17 = 17'(mid) - pm;
                d117 = 17'(mid) + q1_reg;
                d217 = 17'(mid) + q2_reg;
            end
            else
            begin
                dc17 = 17'(mid) + pm;
                d117 = 17'(mid) - q1_reg;
                d217 = 17'(mid) - q2_reg;
            end
        end
        else
        begin
            dc17 = 17'(mid); d117 = q1_reg; d217 = q2_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        armed_next  = armed_reg;
        issued_next = issued_reg;
        tries_next  = tries_reg;
        ovalid_next = ovalid_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        temp_next   = temp_reg;
        vbat_next   = vbat_reg;
        cap_next    = cap_reg;
        mode_next   = mode_reg;
        dm_next     = dm_reg;
        limit_next  = limit_reg;
        lowbat_next = lowbat_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        total_next  = total_reg;
        n1_next     = n1_reg;
        q1_next     = q1_reg;
        q2_next     = q2_reg;
        o_en_next   = o_en_reg;
        o_lim_next  = o_lim_reg;
        o_low_next  = o_low_reg;
        o_dc_next   = o_dc_reg;
        o_d1_next   = o_d1_reg;
        o_d2_next   = o_d2_reg;

        if (results.valid && results.ready)
            ovalid_next = 1'b0;

        if (map_active)
        begin
            if (!issued_reg)
                issued_next = 1'b1;
            else if (rsp.done)
                issued_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    armed_next  = arm_in;
                    v1_next     = flags_reg[3] ? -sw1 : sw1;
                    v2_next     = flags_reg[4] ? -sw2 : sw2;
                    temp_next   = items.temperature_c;
                    vbat_next   = items.battery_voltage;
                    cap_next    = items.current_duty_cap;
                    mode_next   = flags_reg[7] ? items.mode_select : split_reg;
                    dm_next     = dead_dm[16] ? 16'd0 : dead_dm[15:0];
                    limit_next  = 1'b0;
                    lowbat_next = 1'b0;
                    tries_next  = '0;
                    state_next  = arm_in ? S_TEMP : S_FIN;
                end
            end
            S_TEMP:
            begin
                if (!temp_hot)
                    state_next = S_CUR;
                else if (issued_reg && rsp.done)
                begin
                    dm_next    = (half_p == 15'd0) ? rsp.quo[15:0]
                                                   : 16'(17'(half_p) - rsp.quo);
                    limit_next = 1'b1;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                if (cur_cut)
                begin
                    if (cap_reg < dm_reg - (dm_reg >> 3))
                        limit_next = 1'b1;
                    dm_next = cap_reg;
                end
                state_next = S_UV;
            end
            S_UV:
            begin
                if (!uv_act)
                    state_next = S_P1;
                else if (issued_reg && rsp.done)
                begin
                    dm_next     = rsp.quo[15:0];
                    lowbat_next = 1'b1;
                    state_next  = S_P1;
                end
            end
            S_P1:
            begin
                if (issued_reg && rsp.done)
                begin
                    p1_next    = rsp.quo;
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                if (issued_reg && rsp.done)
                begin
                    p2_next    = rsp.quo;
                    total_next = p1_reg + rsp.quo;
                    if (all_zero)
                        state_next = S_FIN;
                    else if (mode_reg == MODE_BOOST_ALL)
                        state_next = (pos2 || neg2) ? S_FIN : S_CHK;
                    else
                        state_next = S_MA;
                end
            end
            S_CHK:
            begin
                if (tries_reg < 2'd2 && total_reg > 17'(dm_reg))
                    state_next = S_SC1;
                else
                    state_next = S_FIN;
            end
            S_SC1:
            begin
                if (issued_reg && rsp.done)
                begin
                    n1_next    = rsp.quo;
                    state_next = S_SC2;
                end
            end
            S_SC2:
            begin
                if (issued_reg && rsp.done)
                begin
                    p1_next    = n1_reg;
                    p2_next    = rsp.quo;
                    total_next = n1_reg + rsp.quo;
                    tries_next = tries_reg + 2'd1;
                    state_next = S_CHK;
                end
            end
            S_MA:
            begin
                if (!map_active)
                begin
                    q1_next    = '0;
                    state_next = S_MB;
                end
                else if (issued_reg && rsp.done)
                begin
                    q1_next    = rsp.quo;
                    state_next = S_MB;
                end
            end
            S_MB:
            begin
                if (!map_active)
                begin
                    q2_next    = '0;
                    state_next = S_FIN;
                end
                else if (issued_reg && rsp.done)
                begin
                    q2_next    = rsp.quo;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next = 1'b1;
                    o_en_next   = armed_reg;
                    o_dc_next   = armed_reg ? sat16(dc17) : 16'd0;
                    o_d1_next   = armed_reg ? sat16(d117) : 16'd0;
                    o_d2_next   = armed_reg ? sat16(d217) : 16'd0;
                    o_lim_next  = armed_reg && limit_reg;
                    o_low_next  = armed_reg && lowbat_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            armed_reg   <= 1'b0;
            issued_reg  <= 1'b0;
            tries_reg   <= '0;
            ovalid_reg  <= 1'b0;
            period_reg  <= 16'd2000;
            dead_reg    <= '0;
            tlim_reg    <= '0;
            vlim_reg    <= '0;
            stretch_reg <= '0;
            split_reg   <= '0;
            flags_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            armed_reg  <= armed_next;
            issued_reg <= issued_next;
            tries_reg  <= tries_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PERIOD:   period_reg  <= cfg_data;
                    CFG_DEADTIME: dead_reg    <= cfg_data[9:0];
                    CFG_TLIMIT:   tlim_reg    <= cfg_data[7:0];
                    CFG_VLIMIT:   vlim_reg    <= cfg_data;
                    CFG_STRETCH:  stretch_reg <= cfg_data;
                    CFG_SPLIT:    split_reg   <= cfg_data[1:0];
                    CFG_FLAGS:    flags_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        temp_reg   <= temp_next;
        vbat_reg   <= vbat_next;
        cap_reg    <= cap_next;
        mode_reg   <= mode_next;
        dm_reg     <= dm_next;
        limit_reg  <= limit_next;
        lowbat_reg <= lowbat_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        total_reg  <= total_next;
        n1_reg     <= n1_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        o_en_reg   <= o_en_next;
        o_lim_reg  <= o_lim_next;
        o_low_reg  <= o_low_next;
        o_dc_reg   <= o_dc_next;
        o_d1_reg   <= o_d1_next;
        o_d2_reg   <= o_d2_next;
    end

    assign items.ready           = (state_reg == S_IDLE);
    assign results.valid         = ovalid_reg;
    assign results.drive_enabled = o_en_reg;
    assign results.duty_common   = o_dc_reg;
    assign results.duty_leg_one  = o_d1_reg;
    assign results.duty_leg_two  = o_d2_reg;
    assign results.limit_active  = o_lim_reg;
    assign results.low_battery   = o_low_reg;

endmodule

[rtl/dmx_muldiv.sv]
// Shared multiply then restoring divide unit, one quotient bit per cycle.
module dmx_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  dmx_pkg::map_req_t req,
    output dmx_pkg::map_rsp_t rsp
);
    import dmx_pkg::*;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_DONE = 4'b1000
    } ustate_t;

    ustate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [15:0]        a_reg;
    logic [15:0]        b_reg;
    logic [16:0]        den_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [16:0]        rem_reg;
    logic [17:0]        rem_sh;
    logic               take;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign take   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                        state_reg <= U_MUL;
                end
                U_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                        state_reg <= U_DONE;
                end
                U_DONE:  state_reg <= U_IDLE;
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            den_reg <= req.den;
        end
        if (state_reg == U_MUL)
        begin
            num_reg <= NUM_W'(a_reg * b_reg);
            rem_reg <= '0;
        end
        else if (state_reg == U_DIV)
        begin
            // quotient bits shift in where dividend bits leave
            num_reg <= {num_reg[NUM_W-2:0], take};
            rem_reg <= take ? 17'(rem_sh - {1'b0, den_reg}) : rem_sh[16:0];
        end
    end

    assign rsp.done = (state_reg == U_DONE);
    assign rsp.quo  = num_reg[16:0];

endmodule
